### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared clocked assertion forms for the checker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that stays live during reset
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/njss_pkg.sv
// ---------------------------------------------------------------------------
// njss_pkg
// Types, constants and register codes for the joint solution selector.
// ---------------------------------------------------------------------------
package njss_pkg;

  localparam int JOINT_COUNT = 6;
  localparam int ANGLE_BITS  = 18;
  localparam int DIST_BITS   = 23;

  // Q4.13 radians
  localparam int PI_Q13     = 25736;
  localparam int TWO_PI_Q13 = 51472;
  localparam int LIMIT_RESET = 81920;

  // lane arithmetic width: room for the angle, the 2*pi offset and a difference
  localparam int LANE_BASE = (ANGLE_BITS > 17) ? ANGLE_BITS : 17;
  localparam int LANE_W    = LANE_BASE + 3;
  localparam int SUM_W     = LANE_W + $clog2(JOINT_COUNT) + 1;
  localparam int CFG_IDX_W = 1;

  typedef logic signed [ANGLE_BITS-1:0] angle_t;
  typedef logic signed [LANE_W-1:0]     lane_s_t;
  typedef logic [LANE_W-1:0]            lane_dist_t;
  typedef logic [DIST_BITS-1:0]         dist_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DISTANCE_LIMIT = 1'b0,
    REG_ELBOW_FILTER   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic  win;
    dist_t total;
  } merge_t;

  localparam lane_s_t TWO_PI_X    = lane_s_t'(TWO_PI_Q13);
  localparam lane_s_t ANGLE_MIN_X = lane_s_t'(-(64'sd1 <<< (ANGLE_BITS - 1)));
  localparam angle_t  ANGLE_MIN   = angle_t'(-(64'sd1 <<< (ANGLE_BITS - 1)));
  localparam angle_t  PI_ANGLE    = angle_t'(PI_Q13);
  localparam dist_t   DIST_MAX    = {DIST_BITS{1'b1}};

endpackage

### hw/rtl/njss_lane.sv
// ---------------------------------------------------------------------------
// njss_lane
// One joint: distance to the reference, plain or one turn down, and the
// angle that goes with the shorter one.
// ---------------------------------------------------------------------------
module njss_lane
  import njss_pkg::*;
(
  input  angle_t     angle,
  input  angle_t     ref_angle,
  output lane_dist_t distance,
  output angle_t     cand
);

  lane_s_t    a_x;
  lane_s_t    b_x;
  lane_s_t    shifted;
  lane_s_t    diff_plain;
  lane_s_t    diff_shift;
  lane_dist_t mag_plain;
  lane_dist_t mag_shift;
  logic       take_shift;

  assign a_x        = lane_s_t'(angle);
  assign b_x        = lane_s_t'(ref_angle);
  assign shifted    = a_x - TWO_PI_X;
  assign diff_plain = a_x - b_x;
  assign diff_shift = shifted - b_x;
  assign mag_plain  = diff_plain[LANE_W-1] ? lane_dist_t'(-diff_plain) : lane_dist_t'(diff_plain);
  assign mag_shift  = diff_shift[LANE_W-1] ? lane_dist_t'(-diff_shift) : lane_dist_t'(diff_shift);

  // tie keeps the unshifted angle
  assign take_shift = mag_plain > mag_shift;

  always_comb begin
    if (take_shift) begin
      distance = mag_shift;
      cand     = (shifted < ANGLE_MIN_X) ? ANGLE_MIN : shifted[ANGLE_BITS-1:0];
    end else begin
      distance = mag_plain;
      cand     = angle;
    end
  end

endmodule

### hw/rtl/njss_merge.sv
// ---------------------------------------------------------------------------
// njss_merge
// Sums the lane distances, saturates, and tests against the running best
// or the limit.
// ---------------------------------------------------------------------------
module njss_merge
  import njss_pkg::*;
(
  input  lane_dist_t lane_dist [JOINT_COUNT],
  input  logic       have_best,
  input  dist_t      best_distance,
  input  dist_t      distance_limit,
  output merge_t     result
);

  logic [SUM_W-1:0] sum;
  dist_t            sum_sat;
  dist_t            threshold;

  always_comb begin
    sum = '0;
    for (int j = 0; j < JOINT_COUNT; j++) begin
      sum = sum + SUM_W'(lane_dist[j]);
    end
  end

  assign sum_sat   = (sum > SUM_W'(DIST_MAX)) ? DIST_MAX : sum[DIST_BITS-1:0];
  assign threshold = have_best ? best_distance : distance_limit;

  // strictly below: the first of equal sums stays
  assign result.win   = sum_sat < threshold;
  assign result.total = sum_sat;

endmodule

### hw/rtl/nearest_joint_solution_select_unit.sv
// ---------------------------------------------------------------------------
// nearest_joint_solution_select_unit
// Picks, per path point, the candidate joint solution nearest the reference.
// ---------------------------------------------------------------------------
// Takes one item per clock. Each item is handled completely in the cycle it
// is accepted: six joint lanes measure plain and one-turn-down distances
// side by side, an adder tree sums them and one compare decides the best,
// so the next candidate sees the updated best at once. The result of a
// point's last candidate sits in an output register; in_ready drops only
// while that register holds a result that has not been taken. Reference
// items and non-final candidates produce no result. out_valid rises in the
// cycle after the last candidate is accepted.
// ---------------------------------------------------------------------------
module nearest_joint_solution_select_unit
  import njss_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIST_BITS-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 kind,
  input  angle_t               angle_0,
  input  angle_t               angle_1,
  input  angle_t               angle_2,
  input  angle_t               angle_3,
  input  angle_t               angle_4,
  input  angle_t               angle_5,
  input  logic                 last_candidate,
  output logic                 out_valid,
  input  logic                 out_ready,
  output angle_t               best_0,
  output angle_t               best_1,
  output angle_t               best_2,
  output angle_t               best_3,
  output angle_t               best_4,
  output angle_t               best_5,
  output logic                 found
);

  dist_t      distance_limit;
  logic       elbow_filter_enable;
  angle_t     reference_angles [JOINT_COUNT];
  angle_t     best_angles      [JOINT_COUNT];
  dist_t      best_distance;
  logic       have_best;
  angle_t     best_out         [JOINT_COUNT];

  angle_t     in_angles [JOINT_COUNT];
  lane_dist_t lane_dist [JOINT_COUNT];
  angle_t     lane_cand [JOINT_COUNT];
  merge_t     merge;
  logic       accept;
  logic       dropped;
  logic       take;
  logic       have_best_next;

  assign in_angles[0] = angle_0;
  assign in_angles[1] = angle_1;
  assign in_angles[2] = angle_2;
  assign in_angles[3] = angle_3;
  assign in_angles[4] = angle_4;
  assign in_angles[5] = angle_5;

  genvar g;
  generate
    for (g = 0; g < JOINT_COUNT; g++) begin : g_lane
      njss_lane u_lane (
        .angle     (in_angles[g]),
        .ref_angle (reference_angles[g]),
        .distance  (lane_dist[g]),
        .cand      (lane_cand[g])
      );
    end
  endgenerate

  njss_merge u_merge (
    .lane_dist      (lane_dist),
    .have_best      (have_best),
    .best_distance  (best_distance),
    .distance_limit (distance_limit),
    .result         (merge)
  );

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // elbow filter: joint 1 must be at or above pi
  assign dropped        = elbow_filter_enable && (angle_1 < PI_ANGLE);
  assign take           = kind && !dropped && merge.win;
  assign have_best_next = have_best || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      distance_limit      <= dist_t'(LIMIT_RESET);
      elbow_filter_enable <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DISTANCE_LIMIT: distance_limit      <= cfg_data;
        REG_ELBOW_FILTER:   elbow_filter_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < JOINT_COUNT; j++) begin
        reference_angles[j] <= '0;
        best_angles[j]      <= '0;
      end
      best_distance <= dist_t'(LIMIT_RESET);
      have_best     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (accept && kind && last_candidate) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        if (!kind) begin
          reference_angles <= in_angles;
        end else begin
          if (take) begin
            best_angles <= lane_cand;
          end
          if (last_candidate) begin
            found <= have_best_next;
            for (int j = 0; j < JOINT_COUNT; j++) begin
              if (have_best_next) begin
                reference_angles[j] <= take ? lane_cand[j] : best_angles[j];
                best_out[j]         <= take ? lane_cand[j] : best_angles[j];
              end else begin
                best_out[j] <= '0;
              end
            end
            best_distance <= distance_limit;
            have_best     <= 1'b0;
          end else if (take) begin
            best_distance <= merge.total;
            have_best     <= 1'b1;
          end
        end
      end
    end
  end

  assign best_0 = best_out[0];
  assign best_1 = best_out[1];
  assign best_2 = best_out[2];
  assign best_3 = best_out[3];
  assign best_4 = best_out[4];
  assign best_5 = best_out[5];

endmodule

### hw/rtl/njss_checker.sv
// ---------------------------------------------------------------------------
// njss_checker
// Port-level checks on the joint solution selector.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module njss_checker
  import njss_pkg::*;
(
  input logic   clk,
  input logic   rst,
  input logic   in_valid,
  input logic   in_ready,
  input logic   kind,
  input logic   last_candidate,
  input logic   out_valid,
  input logic   out_ready,
  input angle_t best_0,
  input angle_t best_1,
  input angle_t best_2,
  input angle_t best_3,
  input angle_t best_4,
  input angle_t best_5,
  input logic   found
);

  logic                            last_fire;
  logic                            other_fire;
  logic                            all_zero;
  logic                            out_stall;
  logic [JOINT_COUNT*ANGLE_BITS:0] res_bits;

  assign last_fire  = in_valid && in_ready && kind && last_candidate;
  assign other_fire = in_valid && in_ready && !(kind && last_candidate);
  assign all_zero   = (best_0 == '0) && (best_1 == '0) && (best_2 == '0) &&
                      (best_3 == '0) && (best_4 == '0) && (best_5 == '0);
  assign out_stall  = out_valid && !out_ready;
  assign res_bits   = {found, best_5, best_4, best_3, best_2, best_1, best_0};

  // a final candidate always yields an item next cycle
  `ASSERT_CLK(a_last_emits, clk, rst, last_fire |=> out_valid, "last candidate gave no result")

  // reference items and non-final candidates yield nothing
  `ASSERT_CLK(a_no_spurious, clk, rst, other_fire |=> !out_valid, "stray result")

  // with no winner the angles read zero
  `ASSERT_CLK(a_not_found_zero, clk, rst, (out_valid && !found) |-> all_zero, "angles not zero")

  // input side stalls only behind an untaken result
  `ASSERT_CLK(a_ready_free, clk, rst, !out_valid |-> in_ready, "input stalled with empty output")

  // stalled result holds
  `ASSERT_CLK(a_hold, clk, rst, out_stall |=> (out_valid && $stable(res_bits)), "result changed")

endmodule

bind nearest_joint_solution_select_unit njss_checker u_njss_checker (.*);
